// ----- hw/rtl/brbuf_pkg.sv -----
// shared types and codes for the byte ring buffer
// no dependencies; used by brbuf_ctrl, brbuf_dp and the top level

package brbuf_pkg;

  // operation codes
  localparam logic [1:0] OP_PUT     = 2'd0;
  localparam logic [1:0] OP_PEEK    = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // saturation value of the reported level
  localparam logic [7:0] LEVEL_MAX = 8'd255;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [7:0] peek_offset;
    logic [7:0] consume_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       accepted;
    logic [7:0] amount_consumed;
    logic [7:0] fill_level;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic put;
    logic peek;
    logic consume;
    logic clear;
    logic out_now;
    logic out_peek;
  } cmd_t;

endpackage

// ----- hw/rtl/brbuf_ctrl.sv -----
// controller for the byte ring buffer: handshakes, peek sequencing, result valid
// depends on brbuf_pkg

module brbuf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        op_i,
  input  logic              out_stall_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output brbuf_pkg::cmd_t   cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PEEK = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic accept;

  // output register is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.put      = accept && (op_i == brbuf_pkg::OP_PUT);
    cmd_o.peek     = accept && (op_i == brbuf_pkg::OP_PEEK);
    cmd_o.consume  = accept && (op_i == brbuf_pkg::OP_CONSUME);
    cmd_o.clear    = accept && (op_i == brbuf_pkg::OP_CLEAR);
    cmd_o.out_now  = accept && (op_i != brbuf_pkg::OP_PEEK);
    cmd_o.out_peek = (state_q == ST_PEEK);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.peek) begin
          state_d = ST_PEEK;
        end
      end
      ST_PEEK: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_now || cmd_o.out_peek) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // peek read data returns in the cycle after the read is issued
  a_peek_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PEEK |=> state_q == ST_IDLE)
    else $error("peek wait state held more than one cycle");

  // a peek is only started when the output register will be empty
  a_peek_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PEEK |-> !out_valid_q)
    else $error("pending result present while peek completes");

  // a new result never overwrites one still waiting for transfer
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_now || cmd_o.out_peek) |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

endmodule

// ----- hw/rtl/brbuf_dp.sv -----
// datapath for the byte ring buffer: byte store, pointers, fill and result register
// depends on brbuf_pkg

module brbuf_dp #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  brbuf_pkg::cmd_t       cmd_i,
  input  brbuf_pkg::in_item_t   in_data_i,
  output brbuf_pkg::out_item_t  out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = (AW > 8) ? AW : 8;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] rp_q, rp_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] fill_q, fill_d;
  // slots below this count were written since the last clear; the rest read as zero
  logic [CW-1:0] hw_q, hw_d;
  logic [7:0]    rd_q;
  logic [AW-1:0] slot_q;
  logic          peek_ok_q;
  brbuf_pkg::out_item_t out_q;

  logic [AW-1:0] off_mod [256];
  logic [AW:0]   slot_sum;
  logic [AW-1:0] slot;
  logic          room;
  logic [WW-1:0] fill_w;
  logic [WW-1:0] count_w;
  logic [WW-1:0] n_w;
  logic [AW-1:0] n_a;
  logic [AW:0]   rp_sum;
  logic [AW-1:0] rp_adv;
  logic [AW-1:0] wp_inc;
  logic          peek_ok;
  logic [7:0]    level;

  // offset reduced modulo the depth, fixed at elaboration
  for (genvar g = 0; g < 256; g++) begin : g_off_mod
    localparam int unsigned OFF = g % DEPTH;
    assign off_mod[g] = AW'(OFF);
  end

  always_comb begin
    slot_sum = {1'b0, rp_q} + {1'b0, off_mod[in_data_i.peek_offset]};
    slot     = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH)) : slot_sum[AW-1:0];

    fill_w  = WW'(fill_q);
    count_w = WW'(in_data_i.consume_count);
    peek_ok = WW'(in_data_i.peek_offset) < fill_w;
    n_w     = (count_w < fill_w) ? count_w : fill_w;
    n_a     = AW'(n_w);

    rp_sum = {1'b0, rp_q} + {1'b0, n_a};
    rp_adv = (rp_sum >= (AW+1)'(DEPTH)) ? AW'(rp_sum - (AW+1)'(DEPTH)) : rp_sum[AW-1:0];

    room   = fill_q != AW'(DEPTH - 1);
    wp_inc = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);

    rp_d   = rp_q;
    wp_d   = wp_q;
    fill_d = fill_q;
    hw_d   = hw_q;
    if (cmd_i.put && room) begin
      wp_d   = wp_inc;
      fill_d = fill_q + AW'(1);
      if (CW'(wp_q) == hw_q) begin
        hw_d = hw_q + CW'(1);
      end
    end
    if (cmd_i.consume) begin
      rp_d   = rp_adv;
      fill_d = fill_q - n_a;
    end
    if (cmd_i.clear) begin
      rp_d   = '0;
      wp_d   = '0;
      fill_d = '0;
      hw_d   = '0;
    end

    level = (WW'(fill_d) >= WW'(brbuf_pkg::LEVEL_MAX)) ? brbuf_pkg::LEVEL_MAX : 8'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      wp_q   <= '0;
      fill_q <= '0;
      hw_q   <= '0;
    end else begin
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      fill_q <= fill_d;
      hw_q   <= hw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put && room) begin
      mem[wp_q] <= in_data_i.data_byte;
    end
    if (cmd_i.peek) begin
      rd_q <= mem[slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.peek) begin
      slot_q    <= slot;
      peek_ok_q <= peek_ok;
    end
    if (cmd_i.out_now) begin
      out_q.read_byte       <= '0;
      out_q.accepted        <= cmd_i.put && room;
      out_q.amount_consumed <= cmd_i.consume ? 8'(n_w) : 8'd0;
      out_q.fill_level      <= level;
    end else if (cmd_i.out_peek) begin
      out_q.read_byte       <= (CW'(slot_q) < hw_q) ? rd_q : 8'd0;
      out_q.accepted        <= peek_ok_q;
      out_q.amount_consumed <= '0;
      out_q.fill_level      <= level;
    end
  end

  assign out_data_o = out_q;

  a_hw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= CW'(DEPTH))
    else $error("written-slot count beyond depth");

  // fill level agrees with the distance between the pointers
  a_fill_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q >= rp_q) ? (fill_q == wp_q - rp_q)
                   : (int'(fill_q) + int'(rp_q) == int'(wp_q) + int'(DEPTH)))
    else $error("fill level out of step with pointers");

  // every held byte sits in a slot written since the last clear
  a_held_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(fill_q) <= hw_q)
    else $error("held data in unwritten slots");

endmodule

// ----- hw/rtl/byte_ring_buffer_peek_consume_top.sv -----
// channel   | dir | handshake               | payload
// input     | in  | in_valid_i / in_stall_o  | in_data_i  (brbuf_pkg::in_item_t)
// result    | out | out_valid_o / out_stall_i| out_data_o (brbuf_pkg::out_item_t)
//
// put, consume and clear are answered from the accepted item; a peek adds the
// registered read port of the byte store and a wait state. one result per item,
// held in an output register that takes a new item while empty or draining, so
// a stalled result blocks new items only once the register is full. reset
// leaves the buffer empty, every slot reading zero at once; no clearing pass.
// depends on brbuf_pkg, brbuf_ctrl, brbuf_dp

module byte_ring_buffer_peek_consume_top #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  brbuf_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output brbuf_pkg::out_item_t  out_data_o
);

  brbuf_pkg::cmd_t cmd;

  brbuf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (in_data_i.operation),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  brbuf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- verif/tb_byte_ring_buffer_peek_consume_top.sv -----
// testbench for byte_ring_buffer_peek_consume_top: random put/peek/consume/clear traffic
// checked against a ring model held in a scoreboard class, with random idle and stall
// depends on brbuf_pkg and the rtl of the top level

module tb_byte_ring_buffer_peek_consume_top;

  localparam int unsigned RING_SLOTS   = 256;
  localparam int unsigned ITEM_TARGET  = 900;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_IDLE     = 6;
  localparam int          RUN_LIMIT    = 800000;

  class ring_scoreboard;
    logic [7:0] slots [RING_SLOTS];
    logic [7:0] rd_ptr;
    logic [7:0] wr_ptr;
    brbuf_pkg::out_item_t awaited_results [$];
    int         errors;
    int         results_seen;
    int         op_count [4];
    int         puts_dropped;
    int         peeks_outside;
    int         consumes_clamped;

    function new();
      foreach (slots[i]) slots[i] = '0;
      foreach (op_count[i]) op_count[i] = 0;
      rd_ptr = '0;
      wr_ptr = '0;
      errors = 0;
      results_seen = 0;
      puts_dropped = 0;
      peeks_outside = 0;
      consumes_clamped = 0;
    endfunction

    // pointers are 8 bits wide, so the difference wraps like the ring does
    function logic [7:0] held();
      return wr_ptr - rd_ptr;
    endfunction

    function void apply_op(brbuf_pkg::in_item_t it);
      brbuf_pkg::out_item_t res;
      logic [7:0] level;
      logic [7:0] slot;
      logic [7:0] taken;
      level = held();
      res = '0;
      op_count[it.operation]++;
      case (it.operation)
        brbuf_pkg::OP_PUT: begin
          if (level < RING_SLOTS - 1) begin
            slots[wr_ptr] = it.data_byte;
            wr_ptr = wr_ptr + 8'd1;
            res.accepted = 1'b1;
          end else begin
            puts_dropped++;
          end
        end
        brbuf_pkg::OP_PEEK: begin
          // out-of-range peeks still return whatever sits in the slot
          slot = rd_ptr + it.peek_offset;
          res.read_byte = slots[slot];
          res.accepted = (it.peek_offset < level);
          if (!res.accepted) peeks_outside++;
        end
        brbuf_pkg::OP_CONSUME: begin
          taken = (it.consume_count < level) ? it.consume_count : level;
          if (it.consume_count > level) consumes_clamped++;
          rd_ptr = rd_ptr + taken;
          res.amount_consumed = taken;
        end
        default: begin
          foreach (slots[i]) slots[i] = '0;
          rd_ptr = '0;
          wr_ptr = '0;
        end
      endcase
      res.fill_level = held();
      awaited_results.push_back(res);
    endfunction

    function void check_result(brbuf_pkg::out_item_t got);
      brbuf_pkg::out_item_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing awaited: %p", got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.read_byte !== want.read_byte) begin
        $error("read_byte expected %0d actual %0d", want.read_byte, got.read_byte);
        errors++;
      end
      if (got.accepted !== want.accepted) begin
        $error("accepted expected %0d actual %0d", want.accepted, got.accepted);
        errors++;
      end
      if (got.amount_consumed !== want.amount_consumed) begin
        $error("amount_consumed expected %0d actual %0d", want.amount_consumed,
               got.amount_consumed);
        errors++;
      end
      if (got.fill_level !== want.fill_level) begin
        $error("fill_level expected %0d actual %0d", want.fill_level, got.fill_level);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  brbuf_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  brbuf_pkg::out_item_t out_data;

  ring_scoreboard sb;
  logic           no_idle = 1'b0;
  logic           hold_request = 1'b0;
  int unsigned    items_sent = 0;

  byte_ring_buffer_peek_consume_top #(.DEPTH(RING_SLOTS)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // fields the operation does not use still get random values
  function automatic brbuf_pkg::in_item_t make_op(input logic [1:0] op,
                                                  input logic [7:0] arg);
    brbuf_pkg::in_item_t it;
    it.operation     = op;
    it.data_byte     = 8'($urandom_range(0, 255));
    it.peek_offset   = 8'($urandom_range(0, 255));
    it.consume_count = 8'($urandom_range(0, 255));
    case (op)
      brbuf_pkg::OP_PUT:     it.data_byte = arg;
      brbuf_pkg::OP_PEEK:    it.peek_offset = arg;
      brbuf_pkg::OP_CONSUME: it.consume_count = arg;
      default: ;
    endcase
    return it;
  endfunction

  function automatic logic [7:0] pick_offset();
    logic [7:0] level;
    level = sb.held();
    case ($urandom_range(0, 4))
      0, 1:    return (level == 0) ? 8'd0 : 8'($urandom_range(0, level - 1));
      2:       return level;
      3:       return level - 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_count();
    logic [7:0] level;
    level = sb.held();
    case ($urandom_range(0, 4))
      0, 1:    return 8'($urandom_range(0, level));
      2:       return level;
      3:       return 8'($urandom_range(0, 4));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input brbuf_pkg::in_item_t it);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.apply_op(it);
    items_sent++;
  endtask

  initial begin : result_sink
    int unsigned stall_len;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall_len = draw_gap();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  initial begin : stimulus
    int unsigned burst;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty buffer corners, then a few bytes
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd0));
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd255));
    send_item(make_op(brbuf_pkg::OP_CONSUME, 8'd0));
    send_item(make_op(brbuf_pkg::OP_CONSUME, 8'd255));
    send_item(make_op(brbuf_pkg::OP_PUT, 8'h00));
    send_item(make_op(brbuf_pkg::OP_PUT, 8'hff));
    send_item(make_op(brbuf_pkg::OP_PUT, 8'ha5));
    send_item(make_op(brbuf_pkg::OP_PUT, 8'h5a));
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd0));
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd3));
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd4));
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd255));
    send_item(make_op(brbuf_pkg::OP_CONSUME, 8'd0));
    send_item(make_op(brbuf_pkg::OP_CONSUME, 8'd1));
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd0));
    // clamp to fill level, then peek at slots never written
    send_item(make_op(brbuf_pkg::OP_CONSUME, 8'd255));
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd0));
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd2));
    send_item(make_op(brbuf_pkg::OP_CLEAR, 8'd0));
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd1));
    send_item(make_op(brbuf_pkg::OP_PUT, 8'h3c));
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd0));
    send_item(make_op(brbuf_pkg::OP_CONSUME, 8'd2));

    // back-pressure: the result side is held off, then puts run the ring past full
    send_item(make_op(brbuf_pkg::OP_CLEAR, 8'd0));
    hold_request = 1'b1;
    no_idle = 1'b1;
    repeat (RING_SLOTS + 4) send_item(make_op(brbuf_pkg::OP_PUT, 8'($urandom_range(0, 255))));
    no_idle = 1'b0;
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd254));
    send_item(make_op(brbuf_pkg::OP_PEEK, 8'd255));
    send_item(make_op(brbuf_pkg::OP_CONSUME, 8'd200));

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 260)
                                               : $urandom_range(1, 24);
          if (burst > ITEM_TARGET - items_sent) burst = ITEM_TARGET - items_sent;
          repeat (burst) send_item(make_op(brbuf_pkg::OP_PUT, 8'($urandom_range(0, 255))));
        end
        3, 4: repeat ($urandom_range(1, 8)) send_item(make_op(brbuf_pkg::OP_PEEK,
                                                              pick_offset()));
        5, 6: send_item(make_op(brbuf_pkg::OP_CONSUME, pick_count()));
        7: begin
          // stream read: look at the head, then drop it
          repeat ($urandom_range(1, 10)) begin
            send_item(make_op(brbuf_pkg::OP_PEEK, 8'd0));
            send_item(make_op(brbuf_pkg::OP_CONSUME, 8'd1));
          end
        end
        8: begin
          if ($urandom_range(0, 3) == 0) send_item(make_op(brbuf_pkg::OP_CLEAR, 8'd0));
          else send_item(make_op(brbuf_pkg::OP_CONSUME, pick_count()));
        end
        default: repeat ($urandom_range(1, 4)) send_item(make_op(2'($urandom_range(0, 3)),
                                                                 8'($urandom_range(0, 255))));
      endcase
    end

    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d puts (%0d dropped on full), %0d peeks (%0d out of range)",
             items_sent, sb.op_count[brbuf_pkg::OP_PUT], sb.puts_dropped,
             sb.op_count[brbuf_pkg::OP_PEEK], sb.peeks_outside);
    $display("%0d consumes (%0d clamped), %0d clears, %0d results checked",
             sb.op_count[brbuf_pkg::OP_CONSUME], sb.consumes_clamped,
             sb.op_count[brbuf_pkg::OP_CLEAR], sb.results_seen);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/brbuf_pkg.sv
hw/rtl/brbuf_ctrl.sv
hw/rtl/brbuf_dp.sv
hw/rtl/byte_ring_buffer_peek_consume_top.sv
verif/tb_byte_ring_buffer_peek_consume_top.sv
